// ----- src/bgcs_pkg.sv -----
package bgcs_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_ACCUM      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_READ_CLEAR = 2'd2
  } cmd_e;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_SPATIAL_REC = 2'd1;
  localparam logic [1:0] REG_RANGE_REC   = 2'd2;

  // Fixed field widths
  localparam int unsigned REC_W   = 17;
  localparam int unsigned QNT_W   = 13;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned COUNT_W = 24;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUANT,
    ST_ADDR,
    ST_READ,
    ST_WB,
    ST_OUT
  } state_e;

  // Rounded fixed-point quantization: (v * recip + 0.5), recip in unsigned 1.16, result the integer part
  function automatic logic [QNT_W-1:0] quantize(logic [10:0] v, logic [REC_W-1:0] recip);
    logic [28:0] p;
    p = 29'(v) * 29'(recip) + 29'd32768;
    return p[28:16];
  endfunction

endpackage

// ----- src/bilateral_grid_cost_splat.sv -----
// Each input transfer walks the quantize, address, read, write-back and output
// states before its result loads into the output register; the output state
// waits for a free output register, and no new item is taken until it is done.
// Reset: asynchronous, active low. After reset the block sweeps the cell memory,
// one cell per cycle (DISPARITIES*GRID_ROWS*GRID_COLS*GRID_LEVELS^2 cells, 131072
// by default), and takes no item until done. Config writes are taken throughout.
module bilateral_grid_cost_splat #(
  parameter int unsigned DISPARITIES = 16,
  parameter int unsigned GRID_ROWS   = 8,
  parameter int unsigned GRID_COLS   = 16,
  parameter int unsigned GRID_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: disparity_index[3:0], pixel_row[13:4], pixel_col[24:14],
  //        left_intensity[32:25], right_intensity[40:33], cell_row[43:41],
  //        cell_col[47:44], cell_left_level[50:48], cell_right_level[53:51], zero pad
  input  logic [55:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,

  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: match_cost[7:0], cell_sum[39:8], cell_count[63:40]
  output logic [63:0] m_axis_tdata,
  // tuser: flag[0], set on a clamped coordinate or a saturated cell
  output logic        m_axis_tuser,

  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned REC_W   = bgcs_pkg::REC_W;
  localparam int unsigned QNT_W   = bgcs_pkg::QNT_W;
  localparam int unsigned SUM_W   = bgcs_pkg::SUM_W;
  localparam int unsigned COUNT_W = bgcs_pkg::COUNT_W;
  localparam int unsigned MEM_W   = SUM_W + COUNT_W;

  localparam int unsigned DW = (DISPARITIES > 1) ? $clog2(DISPARITIES) : 1;
  localparam int unsigned RW = $clog2(GRID_ROWS);
  localparam int unsigned CW = $clog2(GRID_COLS);
  localparam int unsigned LW = $clog2(GRID_LEVELS);

  localparam longint unsigned SLICES = 64'(DISPARITIES) * 64'(GRID_ROWS) * 64'(GRID_COLS);
  localparam longint unsigned CELLS  = SLICES * 64'(GRID_LEVELS) * 64'(GRID_LEVELS);
  localparam int unsigned SW = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  // Configuration registers
  logic [7:0]       thresh_q, thresh_d;
  logic [REC_W-1:0] srec_q, srec_d;
  logic [REC_W-1:0] rrec_q, rrec_d;

  // Sequencer
  bgcs_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;

  // Item fields
  logic [1:0]  cmd_q;
  logic [3:0]  disp_q;
  logic [9:0]  prow_q;
  logic [10:0] pcol_q;
  logic [7:0]  lint_q, rint_q;
  logic [2:0]  crow_q;
  logic [3:0]  ccol_q;
  logic [2:0]  cll_q, crl_q;

  // Grid coordinates and cost
  logic [DW-1:0] d_q;
  logic [RW-1:0] r_q;
  logic [CW-1:0] c_q;
  logic [LW-1:0] l_q, rl_q;
  logic [7:0]    cost_q;
  logic          flag_q;
  logic [SW-1:0] slice_q;
  logic [AW-1:0] addr_q;

  // Result held until the output register is free
  logic [7:0]         res_cost_q;
  logic [SUM_W-1:0]   res_sum_q;
  logic [COUNT_W-1:0] res_count_q;
  logic               res_flag_q;

  // Output register
  logic        m_valid_q, m_valid_d;
  logic [63:0] m_data_q;
  logic        m_user_q;

  // Memory port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [MEM_W-1:0] ram_wdata, ram_rdata;

  logic in_xfer, out_load, is_accum, is_clear, is_valid_cmd;

  assign in_xfer      = s_axis_tvalid && s_axis_tready;
  assign out_load     = (state_q == bgcs_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);
  assign is_accum     = (cmd_q == bgcs_pkg::CMD_ACCUM);
  assign is_clear     = (cmd_q == bgcs_pkg::CMD_READ_CLEAR);
  assign is_valid_cmd = is_accum || (cmd_q == bgcs_pkg::CMD_READ) || is_clear;

  // Configuration writes, always accepted
  assign cfg_ready_o = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    srec_d   = srec_q;
    rrec_d   = rrec_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bgcs_pkg::REG_THRESHOLD:   thresh_d = cfg_data_i[7:0];
        bgcs_pkg::REG_SPATIAL_REC: srec_d   = cfg_data_i;
        bgcs_pkg::REG_RANGE_REC:   rrec_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      bgcs_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_CELL) begin
          state_d = bgcs_pkg::ST_IDLE;
        end
      end
      bgcs_pkg::ST_IDLE:  if (in_xfer) state_d = bgcs_pkg::ST_QUANT;
      bgcs_pkg::ST_QUANT: state_d = bgcs_pkg::ST_ADDR;
      bgcs_pkg::ST_ADDR:  state_d = bgcs_pkg::ST_READ;
      bgcs_pkg::ST_READ:  state_d = bgcs_pkg::ST_WB;
      bgcs_pkg::ST_WB:    state_d = bgcs_pkg::ST_OUT;
      bgcs_pkg::ST_OUT:   if (out_load) state_d = bgcs_pkg::ST_IDLE;
      default:            state_d = bgcs_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    case (state_q)
      bgcs_pkg::ST_CLEAR: ram_we = 1'b1;
      bgcs_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      bgcs_pkg::ST_READ:  ram_re = 1'b1;
      bgcs_pkg::ST_WB:    ram_we = is_accum || is_clear;
      default: ;
    endcase
  end

  // Quantize, clamp and cost
  logic [QNT_W-1:0] q_row, q_col, q_lft, q_rgt;
  logic [QNT_W-1:0] w_row, w_col, w_lft, w_rgt;
  logic [7:0]       diff, cost;
  logic             ov_d, ov_r, ov_c, ov_l, ov_rl;

  always_comb begin
    q_row = bgcs_pkg::quantize(11'(prow_q), srec_q);
    q_col = bgcs_pkg::quantize(pcol_q, srec_q);
    q_lft = bgcs_pkg::quantize(11'(lint_q), rrec_q);
    q_rgt = bgcs_pkg::quantize(11'(rint_q), rrec_q);
    w_row = is_accum ? q_row : QNT_W'(crow_q);
    w_col = is_accum ? q_col : QNT_W'(ccol_q);
    w_lft = is_accum ? q_lft : QNT_W'(cll_q);
    w_rgt = is_accum ? q_rgt : QNT_W'(crl_q);
    ov_d  = (QNT_W'(disp_q) >= QNT_W'(DISPARITIES));
    ov_r  = (w_row >= QNT_W'(GRID_ROWS));
    ov_c  = (w_col >= QNT_W'(GRID_COLS));
    ov_l  = (w_lft >= QNT_W'(GRID_LEVELS));
    ov_rl = (w_rgt >= QNT_W'(GRID_LEVELS));
    diff  = (lint_q > rint_q) ? (lint_q - rint_q) : (rint_q - lint_q);
    cost  = (diff < thresh_q) ? diff : thresh_q;
  end

  // Slice index (disparity, row, column) and full cell address
  logic [SW-1:0] slice_d;
  logic [AW-1:0] addr_d;

  assign slice_d = (SW'(d_q) * SW'(GRID_ROWS) + SW'(r_q)) * SW'(GRID_COLS) + SW'(c_q);
  assign addr_d  = (AW'(slice_q) * AW'(GRID_LEVELS) + AW'(l_q)) * AW'(GRID_LEVELS)
                   + AW'(rl_q);

  // Saturating update of the cell read back
  logic [SUM_W-1:0]   old_sum, new_sum;
  logic [COUNT_W-1:0] old_count, new_count;
  logic [SUM_W:0]     sum_ext;
  logic               sat_flag;

  always_comb begin
    old_sum   = ram_rdata[SUM_W-1:0];
    old_count = ram_rdata[MEM_W-1:SUM_W];
    sum_ext   = {1'b0, old_sum} + (SUM_W+1)'(cost_q);
    new_sum   = sum_ext[SUM_W] ? bgcs_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
    new_count = (old_count == bgcs_pkg::COUNT_MAX) ? bgcs_pkg::COUNT_MAX
                                                   : old_count + COUNT_W'(1);
    sat_flag  = sum_ext[SUM_W] || ((new_sum == bgcs_pkg::SUM_MAX) && (cost_q != 8'd0))
                || (new_count == bgcs_pkg::COUNT_MAX);
  end

  // Memory port muxing: clearing sweep or write-back
  assign ram_raddr = addr_d;
  assign ram_waddr = (state_q == bgcs_pkg::ST_CLEAR) ? clr_q : addr_q;
  assign ram_wdata = ((state_q == bgcs_pkg::ST_WB) && is_accum) ? {new_count, new_sum}
                                                                : '0;

  bgcs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bgcs_pkg::ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      thresh_q  <= 8'd255;
      srec_q    <= 17'd65536;
      rrec_q    <= 17'd65536;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
      thresh_q  <= thresh_d;
      srec_q    <= srec_d;
      rrec_q    <= rrec_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= s_axis_tuser;
      disp_q <= s_axis_tdata[3:0];
      prow_q <= s_axis_tdata[13:4];
      pcol_q <= s_axis_tdata[24:14];
      lint_q <= s_axis_tdata[32:25];
      rint_q <= s_axis_tdata[40:33];
      crow_q <= s_axis_tdata[43:41];
      ccol_q <= s_axis_tdata[47:44];
      cll_q  <= s_axis_tdata[50:48];
      crl_q  <= s_axis_tdata[53:51];
    end
    if (state_q == bgcs_pkg::ST_QUANT) begin
      d_q    <= ov_d  ? DW'(DISPARITIES - 1) : DW'(disp_q);
      r_q    <= ov_r  ? RW'(GRID_ROWS - 1)   : RW'(w_row);
      c_q    <= ov_c  ? CW'(GRID_COLS - 1)   : CW'(w_col);
      l_q    <= ov_l  ? LW'(GRID_LEVELS - 1) : LW'(w_lft);
      rl_q   <= ov_rl ? LW'(GRID_LEVELS - 1) : LW'(w_rgt);
      cost_q <= is_accum ? cost : 8'd0;
      flag_q <= ov_d || ov_r || ov_c || ov_l || ov_rl;
    end
    if (state_q == bgcs_pkg::ST_ADDR) begin
      slice_q <= slice_d;
    end
    if (state_q == bgcs_pkg::ST_READ) begin
      addr_q <= addr_d;
    end
    if (state_q == bgcs_pkg::ST_WB) begin
      // unused command code gives an all-zero result
      res_cost_q  <= cost_q;
      res_sum_q   <= !is_valid_cmd ? '0 : (is_accum ? new_sum : old_sum);
      res_count_q <= !is_valid_cmd ? '0 : (is_accum ? new_count : old_count);
      res_flag_q  <= is_valid_cmd && (flag_q || (is_accum && sat_flag));
    end
    if (out_load) begin
      m_data_q <= {res_count_q, res_sum_q, res_cost_q};
      m_user_q <= res_flag_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- src/bgcs_ram.sv -----
module bgcs_ram #(
  parameter int unsigned      WIDTH = 8,
  parameter longint unsigned  DEPTH = 16,
  localparam int unsigned     AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
